[hdl/sprl_pkg.sv]
`timescale 1ns / 1ps

package sprl_pkg;

  // stream command and escape codes
  localparam logic [7:0] CODE_END_FRAME = 8'hFC;
  localparam logic [7:0] CODE_RUN_LINE  = 8'hFD;
  localparam logic [7:0] CODE_INLINE    = 8'hFE;
  localparam logic [7:0] CODE_CLOSE     = 8'hFF;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT  = 2'd2;

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MID_DEPTH_DEF  = 2;
  localparam int OUT_DEPTH_DEF  = 2;

  // largest value the 11-bit counters and registers hold
  localparam int CNT_MAX = 2047;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_of_frame;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [9:0] line_index;
    logic [9:0] start_column;
    logic [7:0] span_length;
    logic [7:0] pixel_value;
    logic       frame_done;
  } span_item_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] code_byte;
    logic       is_end;
    logic       is_run;
    logic       is_inline;
    logic       is_close;
    logic       start_of_frame;
    logic       last_byte;
  } class_item_t;

endpackage

[hdl/sprl_fifo.sv]
`timescale 1ns / 1ps

module sprl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_V = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == DEPTH_V);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // pointers wrap at the depth
  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/sprl_front.sv]
`timescale 1ns / 1ps

module sprl_front
  import sprl_pkg::*;
(
  input  logic        push,
  output logic        full,
  input  byte_item_t  code,
  input  logic        mid_full,
  output logic        mid_wr_en,
  output class_item_t mid_item
);

  assign full      = mid_full;
  assign mid_wr_en = push && !mid_full;

  // decode the byte against the stream codes once, here
  always_comb begin
    mid_item.code_byte      = code.code_byte;
    mid_item.is_end         = (code.code_byte == CODE_END_FRAME);
    mid_item.is_run         = (code.code_byte == CODE_RUN_LINE);
    mid_item.is_inline      = (code.code_byte == CODE_INLINE);
    mid_item.is_close       = (code.code_byte == CODE_CLOSE);
    mid_item.start_of_frame = code.start_of_frame;
    mid_item.last_byte      = code.last_byte;
  end

endmodule

[hdl/sprl_back.sv]
`timescale 1ns / 1ps

module sprl_back
  import sprl_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [10:0] frame_width,
  input  logic [10:0] frame_height,
  input  logic [7:0]  transparent_value,
  input  logic        mid_empty,
  output logic        mid_rd_en,
  input  class_item_t mid_item,
  input  logic        out_full,
  output logic        out_wr_en,
  output span_item_t  out_item
);

  localparam logic [2:0] MODE_CMD       = 3'd0;
  localparam logic [2:0] MODE_RUN_COUNT = 3'd1;
  localparam logic [2:0] MODE_RUN_PIXEL = 3'd2;
  localparam logic [2:0] MODE_LIT       = 3'd3;
  localparam logic [2:0] MODE_LIT_COUNT = 3'd4;
  localparam logic [2:0] MODE_LIT_PIXEL = 3'd5;
  localparam logic [2:0] MODE_DONE      = 3'd6;

  localparam int WCAP = (MAX_WIDTH > CNT_MAX) ? CNT_MAX : MAX_WIDTH;
  localparam int HCAP = (MAX_HEIGHT > CNT_MAX) ? CNT_MAX : MAX_HEIGHT;
  localparam logic [10:0] WCAP_V = 11'(WCAP);
  localparam logic [10:0] HCAP_V = 11'(HCAP);
  localparam logic [10:0] LINE_SAT = 11'(CNT_MAX);

  logic [2:0]  mode;
  logic [10:0] line;
  logic [10:0] col;
  logic [7:0]  held;
  logic [2:0]  mode_next;
  logic [10:0] line_next;
  logic [10:0] col_next;
  logic [7:0]  held_next;

  logic [2:0]  m;
  logic [10:0] ln;
  logic [10:0] cl;
  logic [7:0]  hc;
  logic [10:0] eff_w;
  logic [10:0] eff_h;
  logic [10:0] room;
  logic [7:0]  span_len;
  logic [7:0]  n;
  logic        span_req;
  logic        got;
  logic        bare;
  logic        stop;
  logic        emit;
  logic        take;
  logic [7:0]  pix;

  assign take      = !mid_empty && !out_full;
  assign mid_rd_en = take;
  assign out_wr_en = take && emit;

  assign eff_w = (frame_width < WCAP_V) ? frame_width : WCAP_V;
  assign eff_h = (frame_height < HCAP_V) ? frame_height : HCAP_V;
  assign pix   = mid_item.is_run ? transparent_value : mid_item.code_byte;

  always_comb begin
    // start of frame clears state before the byte is handled
    m  = mid_item.start_of_frame ? MODE_CMD : mode;
    ln = mid_item.start_of_frame ? 11'd0 : line;
    cl = mid_item.start_of_frame ? 11'd0 : col;
    hc = mid_item.start_of_frame ? 8'd0 : held;

    mode_next = m;
    line_next = ln;
    col_next  = cl;
    held_next = hc;
    span_req  = 1'b0;
    span_len  = 8'd0;
    bare      = 1'b0;
    stop      = 1'b0;

    case (m)
      MODE_CMD: begin
        if (mid_item.is_end) begin
          mode_next = MODE_DONE;
          bare      = 1'b1;
          stop      = 1'b1;
        end else if (mid_item.is_close) begin
          line_next = (ln < LINE_SAT) ? ln + 11'd1 : ln;
          col_next  = 11'd0;
          mode_next = MODE_CMD;
        end else if (ln >= eff_h) begin
          mode_next = MODE_DONE;
          bare      = 1'b1;
          stop      = 1'b1;
        end else begin
          col_next  = 11'd0;
          mode_next = mid_item.is_run ? MODE_RUN_COUNT : MODE_LIT;
        end
      end
      MODE_RUN_COUNT: begin
        if (mid_item.is_close) begin
          line_next = (ln < LINE_SAT) ? ln + 11'd1 : ln;
          col_next  = 11'd0;
          mode_next = MODE_CMD;
        end else begin
          held_next = mid_item.code_byte;
          mode_next = MODE_RUN_PIXEL;
        end
      end
      MODE_RUN_PIXEL: begin
        span_req  = 1'b1;
        span_len  = hc;
        mode_next = MODE_RUN_COUNT;
      end
      MODE_LIT: begin
        if (mid_item.is_close) begin
          line_next = (ln < LINE_SAT) ? ln + 11'd1 : ln;
          col_next  = 11'd0;
          mode_next = MODE_CMD;
        end else if (mid_item.is_inline) begin
          mode_next = MODE_LIT_COUNT;
        end else begin
          span_req = 1'b1;
          span_len = 8'd1;
        end
      end
      MODE_LIT_COUNT: begin
        held_next = mid_item.code_byte;
        mode_next = MODE_LIT_PIXEL;
      end
      MODE_LIT_PIXEL: begin
        span_req  = 1'b1;
        span_len  = hc;
        mode_next = MODE_LIT;
      end
      default: begin
        // finished frame, or an unused code: ignore bytes
        mode_next = MODE_DONE;
        stop      = 1'b1;
      end
    endcase

    // span clipped to the room left on the line
    room = eff_w - cl;
    n    = ({3'd0, span_len} < room) ? span_len : room[7:0];
    got  = span_req && (cl < eff_w) && (n != 8'd0);
    if (got) begin
      col_next = cl + {3'd0, n};
    end

    emit = got || bare;
    if (!stop && mid_item.last_byte) begin
      mode_next = MODE_DONE;
      emit      = 1'b1;
      bare      = !got;
    end

    if (bare) begin
      out_item = '0;
    end else begin
      out_item.line_index   = ln[9:0];
      out_item.start_column = cl[9:0];
      out_item.span_length  = n;
      out_item.pixel_value  = pix;
      out_item.frame_done   = mid_item.last_byte && !stop;
    end
    out_item.frame_done = bare || (got && mid_item.last_byte && !stop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CMD;
      line <= '0;
      col  <= '0;
      held <= '0;
    end else if (take) begin
      mode <= mode_next;
      line <= line_next;
      col  <= col_next;
      held <= held_next;
    end
  end

endmodule

[hdl/sprite_rle_line_decoder_unit.sv]
`timescale 1ns / 1ps

// sprite line rle decoder: turns a byte stream into span writes
// input channel: push/full queue, one code byte per transaction with
//   start_of_frame (clear state first) and last_byte flags
// result channel: empty/pop queue; each transaction is one span write
//   (line, start column, clipped length, pixel) or a bare frame-done marker
// config: cfg_write with cfg_index / cfg_data, taken at any edge; index 0 is
//   frame width, 1 frame height, 2 transparent value; other indexes ignored;
//   write only while the decoder has nothing in flight
// throughput: one byte per clock while the result queue has room; the back
//   end's state machine handles one byte a cycle and a span needs only one
//   subtract and compare
// path: an accepted byte is written to the classified-byte queue, then the
//   back end writes its result into the result queue
// stall: when the result queue fills, the back end holds and the byte queue
//   fills behind it, then full rises; no byte or result is dropped
// reset: queues empty, decoder waits for a line command, registers clear
//   to zero, so width and height must be written before a frame
module sprite_rle_line_decoder_unit
  import sprl_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MID_DEPTH  = MID_DEPTH_DEF,
  parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  byte_item_t             code,
  output logic                   empty,
  input  logic                   pop,
  output span_item_t             span,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [7:0]  transparent_value;

  // front to byte queue
  logic        mid_wr_en;
  logic        mid_full;
  class_item_t mid_wr_item;

  // byte queue to back end
  logic                     mid_empty;
  logic                     mid_rd_en;
  logic [$bits(class_item_t)-1:0] mid_rd_bits;
  class_item_t              mid_rd_item;

  // back end to result queue
  logic       out_wr_en;
  logic       out_full;
  span_item_t out_wr_item;
  logic [$bits(span_item_t)-1:0] out_rd_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= '0;
      frame_height      <= '0;
      transparent_value <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width       <= cfg_data;
        REG_FRAME_HEIGHT: frame_height      <= cfg_data;
        REG_TRANSPARENT:  transparent_value <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify bytes
  sprl_front u_front (
    .push      (push),
    .full      (full),
    .code      (code),
    .mid_full  (mid_full),
    .mid_wr_en (mid_wr_en),
    .mid_item  (mid_wr_item)
  );

  // classified-byte queue lets front and back stall apart
  sprl_fifo #(
    .WIDTH ($bits(class_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr_en),
    .wr_data (mid_wr_item),
    .full    (mid_full),
    .rd_en   (mid_rd_en),
    .rd_data (mid_rd_bits),
    .empty   (mid_empty)
  );

  assign mid_rd_item = class_item_t'(mid_rd_bits);

  // back: line state machine and span clipping
  sprl_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .frame_width       (frame_width),
    .frame_height      (frame_height),
    .transparent_value (transparent_value),
    .mid_empty         (mid_empty),
    .mid_rd_en         (mid_rd_en),
    .mid_item          (mid_rd_item),
    .out_full          (out_full),
    .out_wr_en         (out_wr_en),
    .out_item          (out_wr_item)
  );

  // result queue doubles as the output register
  sprl_fifo #(
    .WIDTH ($bits(span_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr_en),
    .wr_data (out_wr_item),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_rd_bits),
    .empty   (empty)
  );

  assign span = span_item_t'(out_rd_bits);

endmodule
